// ===== design/dpcco_pkg.sv =====
// Shared types and constants for the display pixel conversion and cursor overlay stage.
package dpcco_pkg;

  // Frame memory size in bytes and the address width that covers it.
  localparam int unsigned FB_BYTES = 8388608;
  localparam int unsigned FB_ADDR_W = 27;

  // Hardware cursor geometry: square, two bits per pixel.
  localparam int unsigned CURSOR_SIZE = 64;
  localparam int unsigned CUR_POS_W = $clog2(CURSOR_SIZE);
  localparam int unsigned CUR_ROW_BYTES = CURSOR_SIZE / 4;
  localparam int unsigned CUR_ROW_SHIFT = $clog2(CUR_ROW_BYTES);

  // Palette store geometry.
  localparam int unsigned PAL_DEPTH = 256;
  localparam int unsigned PAL_ADDR_W = $clog2(PAL_DEPTH);
  localparam int unsigned PAL_DATA_W = 24;

  // Request operation codes.
  localparam logic OP_RENDER = 1'b0;
  localparam logic OP_PAL_WRITE = 1'b1;

  // Pixel format codes.
  typedef enum logic [1:0] {
    FMT_8BPP  = 2'd0,
    FMT_16BPP = 2'd1,
    FMT_24BPP = 2'd2,
    FMT_OFF   = 2'd3
  } fmt_t;

  // Register indexes on the configuration port.
  typedef logic [2:0] cfg_idx_t;
  localparam cfg_idx_t CFG_DISPLAY_CONTROL = 3'd0;
  localparam cfg_idx_t CFG_ACTIVE_WIDTH = 3'd1;
  localparam cfg_idx_t CFG_CURSOR_CONTROL = 3'd2;
  localparam cfg_idx_t CFG_CURSOR_LOCATION = 3'd3;
  localparam cfg_idx_t CFG_CURSOR_COLORS_ONE_TWO = 3'd4;
  localparam cfg_idx_t CFG_CURSOR_COLOR_THREE = 3'd5;

  localparam logic [11:0] ACTIVE_WIDTH_RESET = 12'd640;

  // Input request payload.
  typedef struct packed {
    logic        operation;
    logic [10:0] pixel_x;
    logic [10:0] pixel_y;
    logic [23:0] pixel_bits;
    logic [7:0]  cursor_pattern_byte;
    logic [7:0]  palette_index;
    logic [23:0] palette_color;
  } in_req_t;

  // Result payload.
  typedef struct packed {
    logic [31:0] pixel_xrgb;
    logic        cursor_hit;
  } out_res_t;

  // Configuration register file contents.
  typedef struct packed {
    logic [2:0]  display_control;
    logic [11:0] active_width;
    logic [31:0] cursor_control;
    logic [31:0] cursor_location;
    logic [31:0] cursor_colors_one_two;
    logic [15:0] cursor_color_three;
  } cfg_t;

endpackage

// ===== design/dpcco_palette.sv =====
// Palette store: 256 x 24-bit memory with one write port and a registered read port.
module dpcco_palette (
  input  logic                                clk,
  input  logic                                wr_en,
  input  logic [dpcco_pkg::PAL_ADDR_W-1:0]    wr_addr,
  input  logic [dpcco_pkg::PAL_DATA_W-1:0]    wr_data,
  input  logic                                rd_en,
  input  logic [dpcco_pkg::PAL_ADDR_W-1:0]    rd_addr,
  output logic [dpcco_pkg::PAL_DATA_W-1:0]    rd_data
);
  import dpcco_pkg::*;

  logic [PAL_DATA_W-1:0] mem [PAL_DEPTH];
  logic [PAL_DATA_W-1:0] rd_data_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port; the data holds until the next read.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== design/dpcco_cfg_regs.sv =====
// Configuration register file for the pixel conversion and cursor stage.
module dpcco_cfg_regs (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  wr_en,
  input  dpcco_pkg::cfg_idx_t   wr_index,
  input  logic [31:0]           wr_data,
  output dpcco_pkg::cfg_t       cfg
);
  import dpcco_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  // Register write decoder; unknown indexes are ignored.
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (wr_index)
        CFG_DISPLAY_CONTROL:       cfg_nxt.display_control = wr_data[2:0];
        CFG_ACTIVE_WIDTH:          cfg_nxt.active_width = wr_data[11:0];
        CFG_CURSOR_CONTROL:        cfg_nxt.cursor_control = wr_data;
        CFG_CURSOR_LOCATION:       cfg_nxt.cursor_location = wr_data;
        CFG_CURSOR_COLORS_ONE_TWO: cfg_nxt.cursor_colors_one_two = wr_data;
        CFG_CURSOR_COLOR_THREE:    cfg_nxt.cursor_color_three = wr_data[15:0];
        default:                   cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.display_control <= '0;
      cfg_r.active_width <= ACTIVE_WIDTH_RESET;
      cfg_r.cursor_control <= '0;
      cfg_r.cursor_location <= '0;
      cfg_r.cursor_colors_one_two <= '0;
      cfg_r.cursor_color_three <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== design/dpcco_pixel_calc.sv =====
// Pixel format conversion and hardware cursor overlay for one registered request.
module dpcco_pixel_calc (
  input  dpcco_pkg::cfg_t                       cfg,
  input  dpcco_pkg::in_req_t                    req,
  input  logic [dpcco_pkg::PAL_DATA_W-1:0]      pal_data,
  output logic                                  emit,
  output dpcco_pkg::out_res_t                   res
);
  import dpcco_pkg::*;

  // Expand an RGB565 value to XRGB8888 with opaque alpha; low bits are zero.
  function automatic logic [31:0] expand565(input logic [15:0] p);
    expand565 = {8'hFF, p[15:11], 3'b000, p[10:5], 2'b00, p[4:0], 3'b000};
  endfunction

  fmt_t                  fmt;
  logic [10:0]           cur_x;
  logic [10:0]           cur_y;
  logic [10:0]           dx;
  logic [10:0]           dy;
  logic                  row_in;
  logic                  col_in;
  logic                  cur_x_visible;
  logic [FB_ADDR_W-1:0]  row_end;
  logic                  mem_ok;
  logic [1:0]            ci;
  logic [31:0]           base_pix;
  logic [15:0]           cur_color;

  // A render request gives a result only when the display is on and the pixel is visible.
  assign fmt = fmt_t'(cfg.display_control[1:0]);
  assign emit = cfg.display_control[2] && (fmt != FMT_OFF) &&
                ({1'b0, req.pixel_x} < cfg.active_width);

  // Convert the raw pixel according to the format.
  always_comb begin
    case (fmt)
      FMT_8BPP:  base_pix = {8'hFF, pal_data};
      FMT_16BPP: base_pix = expand565(req.pixel_bits[15:0]);
      default:   base_pix = {8'hFF, req.pixel_bits};
    endcase
  end

  // Cursor window test, relative to the cursor origin.
  assign cur_x = req.pixel_x;
  assign cur_y = req.pixel_y;
  assign dx = cur_x - cfg.cursor_location[10:0];
  assign dy = cur_y - cfg.cursor_location[26:16];
  assign row_in = (cur_y >= cfg.cursor_location[26:16]) && (dy < 11'(CURSOR_SIZE));
  assign col_in = (cur_x >= cfg.cursor_location[10:0]) && (dx < 11'(CURSOR_SIZE));
  assign cur_x_visible = {1'b0, cfg.cursor_location[10:0]} < cfg.active_width;

  // The cursor row must lie wholly inside frame memory.
  assign row_end = FB_ADDR_W'({cfg.cursor_control[25:4], 4'b0000}) +
                   (FB_ADDR_W'(dy[CUR_POS_W-1:0]) << CUR_ROW_SHIFT) +
                   FB_ADDR_W'(CUR_ROW_BYTES);
  assign mem_ok = row_end <= FB_ADDR_W'(FB_BYTES);

  // Two-bit cursor index for this column within the pattern byte.
  assign ci = req.cursor_pattern_byte[{dx[1:0], 1'b0} +: 2];

  always_comb begin
    case (ci)
      2'd1:    cur_color = cfg.cursor_colors_one_two[15:0];
      2'd2:    cur_color = cfg.cursor_colors_one_two[31:16];
      default: cur_color = cfg.cursor_color_three;
    endcase
  end

  // Replace the pixel where a non-transparent cursor index covers it.
  always_comb begin
    res.pixel_xrgb = base_pix;
    res.cursor_hit = 1'b0;
    if (cfg.cursor_control[31] && row_in && col_in && cur_x_visible && mem_ok &&
        (ci != 2'd0)) begin
      res.pixel_xrgb = expand565(cur_color);
      res.cursor_hit = 1'b1;
    end
  end

endmodule

// ===== design/display_pixel_convert_cursor_overlay_unit.sv =====
// Top level of the scanout pixel conversion and hardware cursor overlay stage.
//
//   Channel  Direction  Signals                                   Moves
//   in       input      in_valid, in_stall, in_data               render or palette write request
//   out      output     out_valid, out_stall, out_data            converted XRGB8888 pixel
//   cfg      input      cfg_valid, cfg_ready, cfg_index, cfg_wdata register write
//
// One request is accepted per cycle while in_stall is low. A result passes through the
// registered palette read in stage one, then through the result register.
// Palette writes and hidden pixels finish without a result.
// rst_n is synchronous and clears the pipeline valids and the configuration registers;
// the palette is not cleared. out_stall holds the result register, and in_stall rises
// only when the request in flight has a result with nowhere to go.
module display_pixel_convert_cursor_overlay_unit (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  dpcco_pkg::in_req_t   in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output dpcco_pkg::out_res_t  out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  dpcco_pkg::cfg_idx_t  cfg_index,
  input  logic [31:0]          cfg_wdata
);
  import dpcco_pkg::*;

  cfg_t                   cfg;
  logic                   in_acc;
  logic                   s1_valid_r;
  logic                   s1_valid_nxt;
  in_req_t                s1_req_r;
  logic [PAL_DATA_W-1:0]  pal_data;
  logic                   s1_emit;
  out_res_t               s1_res;
  logic                   out_free;
  logic                   s1_go;
  logic                   out_valid_r;
  logic                   out_valid_nxt;
  out_res_t               out_data_r;

  // Configuration registers; writes are always taken.
  assign cfg_ready = 1'b1;

  dpcco_cfg_regs u_cfg_regs (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid),
    .wr_index (cfg_index),
    .wr_data  (cfg_wdata),
    .cfg      (cfg)
  );

  // Handshake: stage one moves on when it has no result or the result register frees up.
  assign in_acc = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign s1_go = s1_valid_r && (!s1_emit || out_free);
  assign in_stall = s1_valid_r && !s1_go;

  // Palette written by write requests, read for every accepted render request.
  dpcco_palette u_palette (
    .clk     (clk),
    .wr_en   (in_acc && (in_data.operation == OP_PAL_WRITE)),
    .wr_addr (in_data.palette_index),
    .wr_data (in_data.palette_color),
    .rd_en   (in_acc && (in_data.operation == OP_RENDER)),
    .rd_addr (in_data.pixel_bits[PAL_ADDR_W-1:0]),
    .rd_data (pal_data)
  );

  // Stage one: render request held alongside its palette data.
  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_acc) begin
      s1_valid_nxt = (in_data.operation == OP_RENDER);
    end else if (s1_go) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_req_r <= in_data;
    end
  end

  dpcco_pixel_calc u_pixel_calc (
    .cfg      (cfg),
    .req      (s1_req_r),
    .pal_data (pal_data),
    .emit     (s1_emit),
    .res      (s1_res)
  );

  // Result register.
  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    if (s1_go && s1_emit) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && s1_emit) begin
      out_data_r <= s1_res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data = out_data_r;

`ifndef SYNTHESIS
  // The input is held back only while a request sits in stage one.
  a_stall_needs_s1: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_valid_r)
    else $error("input stalled with stage one empty");

  // A result is loaded only when the result register is free or being taken.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_go && s1_emit) |-> out_free)
    else $error("result register overwritten while stalled");

  // A palette write never occupies stage one.
  a_write_no_s1: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (in_data.operation == OP_PAL_WRITE)) |=> !s1_valid_r)
    else $error("palette write entered stage one");

  // A held result with a pending result behind it must stall the input.
  a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall && s1_valid_r && s1_emit) |-> in_stall)
    else $error("input taken while stage one is blocked");
`endif

endmodule
